### rtl/core/tssd_pkg.sv
package tssd_pkg;

    localparam logic [3:0] ST_CLOSED   = 4'd0;
    localparam logic [3:0] ST_LISTEN   = 4'd1;
    localparam logic [3:0] ST_SYN_SENT = 4'd2;
    localparam logic [3:0] ST_FINWAIT1 = 4'd5;

    localparam int FL_SYN_ACKED = 0;
    localparam int FL_FORCE     = 1;
    localparam int FL_IDLE      = 2;
    localparam int FL_AT_ISS    = 3;
    localparam int FL_RTT_RUN   = 4;

    localparam int SF_SYN = 0;
    localparam int SF_ACK = 1;
    localparam int SF_FIN = 2;
    localparam int SF_PSH = 3;

    localparam logic [4:0] HDR_BASE     = 5'd20;
    localparam logic [4:0] HDR_WITH_MSS = 5'd24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MSS_IN_USE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_MSS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNDATA_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO        = 3'd4;

    localparam logic [15:0] MSS_RESET     = 16'd536;
    localparam logic [15:0] MIN_RTO_RESET = 16'd500;

    typedef struct packed {
        logic [3:0]  conn_state;
        logic [31:0] snd_una;
        logic [31:0] snd_ptr;
        logic [31:0] snd_nxt;
        logic [15:0] snd_wnd;
        logic [15:0] cwind;
        logic [15:0] send_count;
        logic [15:0] queue_bytes;
        logic [4:0]  flag_bits;
        logic [23:0] srtt;
        logic [23:0] mdev;
        logic [12:0] backoff_factor;
    } in_item_t;

    typedef struct packed {
        logic        send_segment;
        logic [15:0] seg_size;
        logic [15:0] data_bytes;
        logic [3:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] new_snd_ptr;
        logic [31:0] new_snd_nxt;
        logic [15:0] resent_add;
        logic [15:0] new_cwind;
        logic [31:0] retx_timeout;
        logic        start_rtt;
        logic [4:0]  header_len;
    } out_item_t;

    typedef struct packed {
        logic [15:0] mss_in_use;
        logic        syndata_enable;
        logic [31:0] max_wait;
        logic [15:0] min_rto;
    } tssd_cfg_t;

endpackage

### rtl/core/tssd_if.sv
interface tssd_in_if
    import tssd_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tssd_out_if
    import tssd_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### rtl/core/tssd_decide.sv
module tssd_decide
    import tssd_pkg::*;
(
    input  in_item_t  item,
    input  tssd_cfg_t cfg,
    output out_item_t res
);

    logic        synack;
    logic        force_send;
    logic        idle;
    logic        at_iss;
    logic        rtt_run;
    logic        quiet;
    logic [15:0] cw_eff;
    logic [31:0] sent;
    logic [15:0] win_min;
    logic [15:0] usable;
    logic [15:0] avail;
    logic [15:0] ssize_a;
    logic [15:0] ssize_b;
    logic [15:0] ssize;
    logic        syn_flag;
    logic        fin_flag;
    logic        psh_flag;
    logic        send;
    logic [15:0] dsize0;
    logic [15:0] dsize;
    logic [31:0] off;
    logic        short_queue;
    logic [32:0] seq_end;
    logic [31:0] d_nxt;
    logic [15:0] resent;
    logic [31:0] new_ptr;
    logic [31:0] d_new;
    logic [31:0] new_nxt;
    logic [26:0] rto_base;
    logic [39:0] rto_prod;
    logic [31:0] rto_sat;
    logic [31:0] rto_clamp;
    logic [31:0] rto;

    always_comb
    begin
        synack     = item.flag_bits[FL_SYN_ACKED];
        force_send = item.flag_bits[FL_FORCE];
        idle       = item.flag_bits[FL_IDLE];
        at_iss     = item.flag_bits[FL_AT_ISS];
        rtt_run    = item.flag_bits[FL_RTT_RUN];
        quiet      = (item.conn_state == ST_CLOSED) || (item.conn_state == ST_LISTEN);
        cw_eff     = idle ? cfg.mss_in_use : item.cwind;

        sent    = item.snd_ptr - item.snd_una;
        win_min = (item.snd_wnd < cw_eff) ? item.snd_wnd : cw_eff;
        if ({16'd0, win_min} > sent)
        begin
            usable = win_min - sent[15:0];
        end
        else if (win_min == 16'd0 && sent == 32'd0)
        begin
            usable = 16'd1;
        end
        else
        begin
            usable = 16'd0;
        end

        avail   = (sent <= {16'd0, item.send_count}) ? (item.send_count - sent[15:0]) : 16'd0;
        ssize_a = (avail < usable) ? avail : usable;
        if (cfg.mss_in_use < ssize_a)
        begin
            ssize_a = cfg.mss_in_use;
        end

        // The Nagle rule holds back a short segment while data is in flight.
        if (sent != 32'd0 && ssize_a < cfg.mss_in_use
            && !(item.conn_state == ST_FINWAIT1 && ssize_a == avail))
        begin
            ssize_b = 16'd0;
        end
        else
        begin
            ssize_b = ssize_a;
        end

        if (!synack && !cfg.syndata_enable)
        begin
            ssize = (at_iss && ssize_b != 16'd0) ? 16'd1 : 16'd0;
        end
        else
        begin
            ssize = ssize_b;
        end

        send     = !quiet && (ssize != 16'd0 || force_send);
        syn_flag = !synack && at_iss;
        if (syn_flag)
        begin
            dsize0 = (ssize != 16'd0) ? (ssize - 16'd1) : 16'd0;
        end
        else
        begin
            dsize0 = ssize;
        end

        // The data offset skips the SYN while it is still unacknowledged.
        off = (!synack && sent != 32'd0) ? (sent - 32'd1) : sent;
        if ({16'd0, item.queue_bytes} > off)
        begin
            short_queue = (item.queue_bytes - off[15:0]) < dsize0;
        end
        else
        begin
            short_queue = dsize0 != 16'd0;
        end
        fin_flag = (dsize0 != 16'd0) && short_queue;
        dsize    = fin_flag ? (dsize0 - 16'd1) : dsize0;

        seq_end  = {1'b0, sent} + {17'd0, ssize};
        psh_flag = (dsize != 16'd0) && (seq_end == {17'd0, item.send_count});

        d_nxt = item.snd_nxt - item.snd_ptr;
        if (d_nxt != 32'd0 && !d_nxt[31])
        begin
            resent = (d_nxt < {16'd0, ssize}) ? d_nxt[15:0] : ssize;
        end
        else
        begin
            resent = 16'd0;
        end

        new_ptr = item.snd_ptr + {16'd0, ssize};
        d_new   = new_ptr - item.snd_nxt;
        new_nxt = (d_new != 32'd0 && !d_new[31]) ? new_ptr : item.snd_nxt;

        rto_base  = {1'b0, item.mdev, 2'b00} + {3'd0, item.srtt};
        rto_prod  = {27'd0, item.backoff_factor} * {13'd0, rto_base};
        rto_sat   = (rto_prod[39:32] != 8'd0) ? 32'hFFFF_FFFF : rto_prod[31:0];
        rto_clamp = (cfg.max_wait != 32'd0 && rto_sat > cfg.max_wait) ? cfg.max_wait
                                                                      : rto_sat;
        if (ssize == 16'd0)
        begin
            rto = 32'd0;
        end
        else if (rto_clamp < {16'd0, cfg.min_rto})
        begin
            rto = {16'd0, cfg.min_rto};
        end
        else
        begin
            rto = rto_clamp;
        end

        res              = '0;
        res.new_snd_ptr  = item.snd_ptr;
        res.new_snd_nxt  = item.snd_nxt;
        res.new_cwind    = quiet ? item.cwind : cw_eff;
        res.header_len   = HDR_BASE;
        if (send)
        begin
            res.send_segment         = 1'b1;
            res.seg_size             = ssize;
            res.data_bytes           = dsize;
            res.seg_flags[SF_SYN]    = syn_flag;
            res.seg_flags[SF_ACK]    = item.conn_state != ST_SYN_SENT;
            res.seg_flags[SF_FIN]    = fin_flag;
            res.seg_flags[SF_PSH]    = psh_flag;
            res.seg_seq              = item.snd_ptr;
            res.new_snd_ptr          = new_ptr;
            res.new_snd_nxt          = new_nxt;
            res.resent_add           = resent;
            res.retx_timeout         = rto;
            res.start_rtt            = (ssize != 16'd0) && !rtt_run;
            res.header_len           = syn_flag ? HDR_WITH_MSS : HDR_BASE;
        end
    end

endmodule

### rtl/core/tcp_send_segment_decide.sv
// Send decision for one TCP connection, one send opportunity per transfer.
// The input channel carries a snapshot of the sender state; the output channel
// returns exactly one result per input transfer: whether a segment goes out,
// its size, flags, sequence number, updated pointers and the retransmit timer.
// The configuration port writes one register per cycle by index; it should be
// used only while no transfer is in progress.
// An accepted item is held in an input register, decided by one pass of
// combinational logic, and captured in the result register. A new item may
// be accepted in every cycle while the receiver does not stall. The longest
// path runs through the 13 by 27 bit timeout multiplier and the clamp
// comparisons after it.
// Reset empties both registers and loads the default register values.
// When the receiver stalls, the result register holds its item and the
// input register takes one more item before the input channel stalls too.
module tcp_send_segment_decide
    import tssd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tssd_in_if.sink               in_ch,
    tssd_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [15:0] mss_in_use_reg;
    logic        syndata_enable_reg;
    logic [31:0] max_wait_reg;
    logic [15:0] min_rto_reg;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    tssd_cfg_t cfg;
    logic      out_move;
    logic      in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_in_use_reg     <= MSS_RESET;
            syndata_enable_reg <= 1'b0;
            max_wait_reg       <= 32'd0;
            min_rto_reg        <= MIN_RTO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MSS_IN_USE:     mss_in_use_reg     <= cfg_data[15:0];
                // The advertised MSS only goes into the SYN header built downstream.
                CFG_SYN_MSS:        ;
                CFG_SYNDATA_ENABLE: syndata_enable_reg <= cfg_data[0];
                CFG_MAX_WAIT:       max_wait_reg       <= cfg_data[31:0];
                CFG_MIN_RTO:        min_rto_reg        <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    assign cfg.mss_in_use     = mss_in_use_reg;
    assign cfg.syndata_enable = syndata_enable_reg;
    assign cfg.max_wait       = max_wait_reg;
    assign cfg.min_rto        = min_rto_reg;

    assign out_move    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || out_move;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_ch.item;
        end
        if (out_move && s1_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    tssd_decide u_decide (
        .item (s1_item_reg),
        .cfg  (cfg),
        .res  (out_item_next)
    );

    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while both stages are full");

    a_idle_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.send_segment)
        |-> (out_item_reg.seg_size == 16'd0 && out_item_reg.retx_timeout == 32'd0
             && out_item_reg.seg_flags == 4'd0))
        else $error("result without a segment carries segment fields");

    a_data_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.data_bytes <= out_item_reg.seg_size))
        else $error("data bytes exceed segment size");

    a_mss_hdr_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.header_len == HDR_WITH_MSS)
        |-> out_item_reg.seg_flags[SF_SYN])
        else $error("MSS option header without SYN");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_move) |=> out_valid_reg)
        else $error("decided item lost between stages");

endmodule

### bench/tb_tcp_send_segment_decide.sv
module tb_tcp_send_segment_decide;
    import tssd_pkg::*;

    localparam logic [3:0] ST_SYN_RCVD    = 4'd3;
    localparam logic [3:0] ST_ESTABLISHED = 4'd4;
    localparam logic [3:0] ST_TIME_WAIT   = 4'd10;
    localparam logic [3:0] ST_UNLISTED    = 4'd15;

    localparam logic [4:0] F_ACKED   = 5'd1 << FL_SYN_ACKED;
    localparam logic [4:0] F_FORCE   = 5'd1 << FL_FORCE;
    localparam logic [4:0] F_IDLE    = 5'd1 << FL_IDLE;
    localparam logic [4:0] F_AT_ISS  = 5'd1 << FL_AT_ISS;
    localparam logic [4:0] F_RTT_RUN = 5'd1 << FL_RTT_RUN;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tssd_in_if  in_ch ();
    tssd_out_if out_ch ();

    tcp_send_segment_decide dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [15:0] cfg_mss;
    logic        cfg_syndata;
    logic [31:0] cfg_max_wait;
    logic [15:0] cfg_min_rto;

    out_item_t pending_results[$];
    int        error_count;
    bit        stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    function automatic logic later_seq(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 32'd0 && d < 32'h8000_0000;
    endfunction

    function automatic out_item_t decide_segment(in_item_t it);
        out_item_t   res;
        logic [63:0] mss, cw, wnd, cnt, qb, sent, usable, avail, ssize, dsize;
        logic [63:0] off, have, resent, rto;
        logic [31:0] new_ptr;
        logic [3:0]  flags;
        logic [4:0]  hlen;
        logic        synack, forced, idle, at_iss, rtt_run;
        synack  = it.flag_bits[FL_SYN_ACKED];
        forced  = it.flag_bits[FL_FORCE];
        idle    = it.flag_bits[FL_IDLE];
        at_iss  = it.flag_bits[FL_AT_ISS];
        rtt_run = it.flag_bits[FL_RTT_RUN];
        res = '0;
        res.new_snd_ptr = it.snd_ptr;
        res.new_snd_nxt = it.snd_nxt;
        res.new_cwind   = it.cwind;
        res.header_len  = HDR_BASE;
        if (it.conn_state == ST_CLOSED || it.conn_state == ST_LISTEN)
            return res;

        mss = {48'd0, cfg_mss};
        wnd = {48'd0, it.snd_wnd};
        cnt = {48'd0, it.send_count};
        qb  = {48'd0, it.queue_bytes};
        cw  = idle ? mss : {48'd0, it.cwind};
        res.new_cwind = cw[15:0];

        sent   = {32'd0, it.snd_ptr - it.snd_una};
        usable = (wnd < cw) ? wnd : cw;
        if (usable > sent)
            usable = usable - sent;
        else if (usable == 0 && sent == 0)
            usable = 1;
        else
            usable = 0;
        avail = (sent <= cnt) ? cnt - sent : 64'd0;
        ssize = (avail < usable) ? avail : usable;
        if (mss < ssize)
            ssize = mss;

        if (sent != 0 && ssize < mss && !(it.conn_state == ST_FINWAIT1 && ssize == avail))
            ssize = 0;
        if (!synack && !cfg_syndata)
            ssize = (at_iss && ssize != 0) ? 64'd1 : 64'd0;
        if (ssize == 0 && !forced)
            return res;

        flags = '0;
        hlen  = HDR_BASE;
        if (it.conn_state != ST_SYN_SENT)
            flags[SF_ACK] = 1'b1;
        dsize = ssize;
        if (!synack && at_iss)
        begin
            flags[SF_SYN] = 1'b1;
            if (dsize != 0)
                dsize = dsize - 1;
            hlen = HDR_WITH_MSS;
        end
        if (dsize != 0)
        begin
            off = sent;
            if (!synack && sent != 0)
                off = off - 1;
            have = (qb > off) ? qb - off : 64'd0;
            if (have < dsize)
            begin
                flags[SF_FIN] = 1'b1;
                dsize = dsize - 1;
            end
        end
        if (dsize != 0 && sent + ssize == cnt)
            flags[SF_PSH] = 1'b1;

        resent = 0;
        if (later_seq(it.snd_nxt, it.snd_ptr))
        begin
            resent = {32'd0, it.snd_nxt - it.snd_ptr};
            if (ssize < resent)
                resent = ssize;
        end
        new_ptr = it.snd_ptr + ssize[31:0];

        rto = 0;
        if (ssize != 0)
        begin
            rto = {51'd0, it.backoff_factor} * ({40'd0, it.mdev} * 4 + {40'd0, it.srtt});
            if (rto > 64'hFFFF_FFFF)
                rto = 64'hFFFF_FFFF;
            if (cfg_max_wait != 0 && rto > {32'd0, cfg_max_wait})
                rto = {32'd0, cfg_max_wait};
            if (rto < {48'd0, cfg_min_rto})
                rto = {48'd0, cfg_min_rto};
            res.start_rtt = !rtt_run;
        end

        res.send_segment = 1'b1;
        res.seg_size     = ssize[15:0];
        res.data_bytes   = dsize[15:0];
        res.seg_flags    = flags;
        res.seg_seq      = it.snd_ptr;
        res.new_snd_ptr  = new_ptr;
        res.new_snd_nxt  = later_seq(new_ptr, it.snd_nxt) ? new_ptr : it.snd_nxt;
        res.resent_add   = resent[15:0];
        res.retx_timeout = rto[31:0];
        res.header_len   = hlen;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            error_count++;
        end
    endtask

    // Result side: random stall bursts, and every transfer is checked against the
    // oldest outstanding prediction.
    initial
    begin
        int        stall_left;
        out_item_t exp_res;
        out_item_t got;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = out_ch.item;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no prediction outstanding");
                    error_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    check_field("send_segment", 32'(exp_res.send_segment),
                                32'(got.send_segment));
                    check_field("seg_size", 32'(exp_res.seg_size), 32'(got.seg_size));
                    check_field("data_bytes", 32'(exp_res.data_bytes), 32'(got.data_bytes));
                    check_field("seg_flags", 32'(exp_res.seg_flags), 32'(got.seg_flags));
                    check_field("seg_seq", exp_res.seg_seq, got.seg_seq);
                    check_field("new_snd_ptr", exp_res.new_snd_ptr, got.new_snd_ptr);
                    check_field("new_snd_nxt", exp_res.new_snd_nxt, got.new_snd_nxt);
                    check_field("resent_add", 32'(exp_res.resent_add), 32'(got.resent_add));
                    check_field("new_cwind", 32'(exp_res.new_cwind), 32'(got.new_cwind));
                    check_field("retx_timeout", exp_res.retx_timeout, got.retx_timeout);
                    check_field("start_rtt", 32'(exp_res.start_rtt), 32'(got.start_rtt));
                    check_field("header_len", 32'(exp_res.header_len), 32'(got.header_len));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_enable && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_opportunity(in_item_t it);
        if (stall_enable && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pending_results.push_back(decide_segment(it));
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(logic [15:0] mss, logic [15:0] syn_mss, logic syndata,
                                 logic [31:0] max_wait, logic [15:0] min_rto);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MSS_IN_USE;
        cfg_data  <= {16'd0, mss};
        @(posedge clk);
        cfg_index <= CFG_SYN_MSS;
        cfg_data  <= {16'd0, syn_mss};
        @(posedge clk);
        cfg_index <= CFG_SYNDATA_ENABLE;
        cfg_data  <= {31'd0, syndata};
        @(posedge clk);
        cfg_index <= CFG_MAX_WAIT;
        cfg_data  <= max_wait;
        @(posedge clk);
        cfg_index <= CFG_MIN_RTO;
        cfg_data  <= {16'd0, min_rto};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_mss      = mss;
        cfg_syndata  = syndata;
        cfg_max_wait = max_wait;
        cfg_min_rto  = min_rto;
    endtask

    function automatic in_item_t make_opportunity(logic [3:0] state, logic [31:0] una,
                                                  logic [31:0] sent, logic [31:0] nxt_off,
                                                  logic [15:0] wnd, logic [15:0] cw,
                                                  logic [15:0] cnt, logic [15:0] qb,
                                                  logic [4:0] flags, logic [23:0] srtt,
                                                  logic [23:0] mdev, logic [12:0] bof);
        in_item_t it;
        it.conn_state     = state;
        it.snd_una        = una;
        it.snd_ptr        = una + sent;
        it.snd_nxt        = una + sent + nxt_off;
        it.snd_wnd        = wnd;
        it.cwind          = cw;
        it.send_count     = cnt;
        it.queue_bytes    = qb;
        it.flag_bits      = flags;
        it.srtt           = srtt;
        it.mdev           = mdev;
        it.backoff_factor = bof;
        return it;
    endfunction

    function automatic in_item_t random_opportunity();
        in_item_t    it;
        logic [31:0] sent;
        it.conn_state = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(2, 10));
        it.snd_una = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:    sent = 32'd0;
            4, 5, 6, 7, 8: sent = $urandom_range(1, 2000);
            default:       sent = $urandom;
        endcase
        it.snd_ptr = it.snd_una + sent;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.snd_nxt = it.snd_ptr;
            5, 6, 7:       it.snd_nxt = it.snd_ptr + $urandom_range(1, 3000);
            8:             it.snd_nxt = it.snd_ptr - $urandom_range(1, 3000);
            default:       it.snd_nxt = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: it.send_count = sent[15:0] + 16'($urandom_range(0, 3000));
            7:                   it.send_count = 16'($urandom);
            8:                   it.send_count = 16'd0;
            default:             it.send_count = sent[15:0];
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: it.queue_bytes = it.send_count;
            6, 7:             it.queue_bytes = it.send_count - 16'($urandom_range(0, 3));
            8:                it.queue_bytes = 16'($urandom);
            default:          it.queue_bytes = 16'd0;
        endcase
        case ($urandom_range(0, 9))
            0, 1:          it.snd_wnd = 16'd0;
            2, 3, 4, 5:    it.snd_wnd = 16'($urandom_range(1, 4000));
            default:       it.snd_wnd = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:             it.cwind = 16'd0;
            1, 2, 3, 4:    it.cwind = 16'($urandom_range(1, 4000));
            default:       it.cwind = 16'($urandom);
        endcase
        it.flag_bits = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 3) != 0)
            it.flag_bits[FL_SYN_ACKED] = 1'b1;
        it.flag_bits[FL_FORCE] = ($urandom_range(0, 3) == 0);
        it.srtt = $urandom_range(0, 1) ? 24'($urandom_range(0, 3000)) : 24'($urandom);
        it.mdev = $urandom_range(0, 1) ? 24'($urandom_range(0, 3000)) : 24'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: it.backoff_factor = 13'd1 << $urandom_range(0, 6);
            6, 7, 8:          it.backoff_factor = 13'($urandom_range(1, 4096));
            default:          it.backoff_factor = 13'd4096;
        endcase
        return it;
    endfunction

    task automatic test_reset_defaults;
        in_item_t it;
        send_opportunity(make_opportunity(ST_CLOSED, 100, 0, 0, 1000, 1000, 1000, 1000,
                                          F_ACKED | F_IDLE, 10, 10, 1));
        send_opportunity(make_opportunity(ST_LISTEN, 100, 0, 0, 1000, 1000, 1000, 1000,
                                          F_ACKED | F_IDLE, 10, 10, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 1000, 0, 0, 16'hFFFF, 16'hFFFF,
                                          3000, 3000, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 5, 0, 0, 16'hFFFF, 16'hFFFF,
                                          300, 300, F_ACKED, 100, 20, 2));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 7, 0, 0, 0, 16'hFFFF,
                                          50, 50, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 9, 100, 0, 10, 16'hFFFF,
                                          200, 200, F_ACKED | F_FORCE, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 9, 100, 0, 16'hFFFF, 16'hFFFF,
                                          50, 50, F_ACKED | F_FORCE, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 9, 10, 0, 16'hFFFF, 16'hFFFF,
                                          100, 100, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_FINWAIT1, 9, 10, 0, 16'hFFFF, 16'hFFFF,
                                          100, 89, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_FINWAIT1, 9, 20, 0, 16'hFFFF, 16'hFFFF,
                                          25, 5, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_SYN_SENT, 300, 0, 0, 16'hFFFF, 16'hFFFF,
                                          1, 0, F_AT_ISS, 100, 20, 1));
        send_opportunity(make_opportunity(ST_SYN_SENT, 300, 0, 0, 16'hFFFF, 16'hFFFF,
                                          0, 0, F_AT_ISS | F_FORCE, 100, 20, 1));
        send_opportunity(make_opportunity(ST_SYN_RCVD, 300, 0, 0, 16'hFFFF, 16'hFFFF,
                                          40, 40, 5'd0, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 11, 0, 0, 16'hFFFF, 16'hFFFF,
                                          10, 0, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_FINWAIT1, 32'hFFFF_FFF0, 32'h20, 0, 16'hFFFF,
                                          16'hFFFF, 16'h30, 16'h30, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 32'hFFFF_FF00, 0, 200, 16'hFFFF,
                                          16'hFFFF, 1000, 1000, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 500, 0, 32'hFFFF_FFFB, 16'hFFFF,
                                          16'hFFFF, 1000, 1000, F_ACKED, 100, 20, 1));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 500, 0, 0, 16'hFFFF, 16'hFFFF,
                                          1000, 1000, F_ACKED, 24'hFFFFFF, 24'hFFFFFF, 4096));
        send_opportunity(make_opportunity(ST_ESTABLISHED, 500, 0, 0, 16'hFFFF, 16'hFFFF,
                                          1000, 1000, F_ACKED | F_RTT_RUN, 0, 0, 1));
        send_opportunity(make_opportunity(ST_TIME_WAIT, 500, 0, 0, 16'hFFFF, 10,
                                          1000, 1000, F_ACKED | F_IDLE, 100, 20, 1));
        send_opportunity(make_opportunity(ST_UNLISTED, 500, 0, 0, 16'hFFFF, 16'hFFFF,
                                          1000, 1000, F_ACKED, 100, 20, 1));
        it = '1;
        it.backoff_factor = 13'd4096;
        send_opportunity(it);
        it = '0;
        it.backoff_factor = 13'd1;
        send_opportunity(it);
    endtask

    task automatic run_random(int count);
        repeat (count) send_opportunity(random_opportunity());
    endtask

    task automatic test_register_extremes;
        set_registers(16'd1460, 16'd1460, 1'b0, 32'd60000, 16'd200);
        run_random(150);
        set_registers(16'd1, 16'd1, 1'b1, 32'd0, 16'd1);
        run_random(150);
        set_registers(16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        run_random(150);
        set_registers(16'd536, 16'd1, 1'b0, 32'd1, 16'hFFFF);
        run_random(150);
    endtask

    task automatic test_random_settings;
        repeat (5)
        begin
            set_registers(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                          1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? 32'($urandom_range(0, 100000)) : $urandom,
                          16'($urandom_range(1, 65535)));
            run_random(200);
        end
    endtask

    task automatic test_back_to_back;
        set_registers(16'd100, 16'd536, 1'b1, 32'd5000, 16'd300);
        stall_enable = 1'b0;
        run_random(310);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.item   = '0;
        error_count  = 0;
        stall_enable = 1'b1;
        cfg_mss      = MSS_RESET;
        cfg_syndata  = 1'b0;
        cfg_max_wait = 32'd0;
        cfg_min_rto  = MIN_RTO_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        test_back_to_back();

        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/core/tssd_pkg.sv
rtl/core/tssd_if.sv
rtl/core/tssd_decide.sv
rtl/core/tcp_send_segment_decide.sv
bench/tb_tcp_send_segment_decide.sv
